[design/tcphp_pkg.sv]
// ----------------------------------------------------------------------------
// TCP header parser package
// Shared constants, option codes, status codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tcphp_pkg;

  localparam int FIXED_LEN        = 20;
  localparam int MAX_OPTION_BYTES = 40;
  localparam int HDR_LIMIT        = FIXED_LEN + MAX_OPTION_BYTES;

  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_TSTAMP = 8'd8;

  localparam logic [7:0] LEN_MSS    = 8'd4;
  localparam logic [7:0] LEN_WSCALE = 8'd3;
  localparam logic [7:0] LEN_TSTAMP = 8'd10;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] port_pair;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [9:0]  flag_bits;
    logic [15:0] window_size;
    logic [15:0] checksum_field;
    logic [15:0] urgent_pointer;
    logic [15:0] mss_value;
    logic [7:0]  scale_value;
    logic [63:0] timestamp_pair;
    logic [5:0]  header_length;
    status_t     parse_status;
  } result_t;

endpackage

`default_nettype wire

[design/tcphp_in_stage.sv]
// ----------------------------------------------------------------------------
// TCP header parser input stage
// Registers one segment beat; holds it while the parser cannot advance.
// ----------------------------------------------------------------------------
`default_nettype none

module tcphp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       seg_valid,
  output logic            seg_stall,
  input  wire logic [7:0] segment_byte,
  input  wire logic       last_byte,
  input  wire logic       advance,
  output logic            beat_valid,
  output logic [7:0]      beat_byte,
  output logic            beat_last
);

  assign seg_stall = beat_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!seg_stall) begin
      beat_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!seg_stall && seg_valid) begin
      beat_byte <= segment_byte;
      beat_last <= last_byte;
    end
  end

endmodule

`default_nettype wire

[design/tcphp_parse.sv]
// ----------------------------------------------------------------------------
// TCP header parser core
// Captures fixed header fields, walks options and forms the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module tcphp_parse (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    beat_byte,
  input  wire logic          beat_last,
  output logic               emit,
  output tcphp_pkg::result_t result
);

  typedef struct packed {
    logic [5:0]        pos;
    logic              done;
    logic [5:0]        offset;
    tcphp_pkg::phase_t phase;
    logic [7:0]        kind;
    logic [7:0]        opt_end;
    logic              opt_accept;
    logic [31:0]       ports;
    logic [31:0]       seq;
    logic [31:0]       ack;
    logic [6:0]        flags;
    logic [47:0]       words;
    logic [15:0]       mss;
    logic [7:0]        scale;
    logic [63:0]       stamp;
    logic [2:0]        present;
  } pstate_t;

  pstate_t st;
  pstate_t st_next;
  pstate_t upd;

  logic [6:0]        p1;
  logic [5:0]        limit;
  logic [7:0]        eff;
  logic [8:0]        end_wide;
  logic [7:0]        end_sat;
  logic              exact;
  logic              reached;
  logic              clear;
  logic [2:0]        pres;
  tcphp_pkg::status_t status;

  always_comb begin
    upd      = st;
    p1       = {1'b0, st.pos} + 7'd1;
    limit    = (st.offset < 6'(tcphp_pkg::HDR_LIMIT)) ? st.offset
                                                      : 6'(tcphp_pkg::HDR_LIMIT);
    eff      = (beat_byte < 8'd2) ? 8'd2 : beat_byte;
    end_wide = {3'b000, st.pos} + {1'b0, eff} - 9'd1;
    end_sat  = end_wide[8] ? 8'hFF : end_wide[7:0];
    exact    = (st.kind == tcphp_pkg::KIND_MSS    && beat_byte == tcphp_pkg::LEN_MSS) ||
               (st.kind == tcphp_pkg::KIND_WSCALE && beat_byte == tcphp_pkg::LEN_WSCALE) ||
               (st.kind == tcphp_pkg::KIND_TSTAMP && beat_byte == tcphp_pkg::LEN_TSTAMP);
    emit     = 1'b0;
    status   = tcphp_pkg::ST_OK;

    if (!st.done) begin
      if ({1'b0, st.pos} < 7'(tcphp_pkg::FIXED_LEN)) begin
        priority if (st.pos < 6'd4) begin
          upd.ports = {st.ports[23:0], beat_byte};
        end else if (st.pos < 6'd8) begin
          upd.seq = {st.seq[23:0], beat_byte};
        end else if (st.pos < 6'd12) begin
          upd.ack = {st.ack[23:0], beat_byte};
        end else if (st.pos == 6'd12) begin
          upd.offset = {beat_byte[7:4], 2'b00};
        end else if (st.pos == 6'd13) begin
          upd.flags = beat_byte[6:0];
        end else begin
          upd.words = {st.words[39:0], beat_byte};
        end
      end else begin
        unique case (st.phase)
          tcphp_pkg::PH_KIND: begin
            if (beat_byte == tcphp_pkg::KIND_EOL) begin
              upd.phase = tcphp_pkg::PH_STOP;
            end else if (beat_byte != tcphp_pkg::KIND_NOP) begin
              upd.kind  = beat_byte;
              upd.phase = tcphp_pkg::PH_LEN;
            end
          end
          tcphp_pkg::PH_LEN: begin
            upd.opt_end    = end_sat;
            upd.opt_accept = exact && (end_sat <= {2'b00, limit});
            if (upd.opt_accept) begin
              priority if (st.kind == tcphp_pkg::KIND_MSS) begin
                upd.present[0] = 1'b1;
              end else if (st.kind == tcphp_pkg::KIND_WSCALE) begin
                upd.present[1] = 1'b1;
              end else begin
                upd.present[2] = 1'b1;
              end
            end
            upd.phase = ({1'b0, p1} >= end_sat) ? tcphp_pkg::PH_KIND : tcphp_pkg::PH_DATA;
          end
          tcphp_pkg::PH_DATA: begin
            if (st.opt_accept) begin
              priority if (st.kind == tcphp_pkg::KIND_MSS) begin
                upd.mss = {st.mss[7:0], beat_byte};
              end else if (st.kind == tcphp_pkg::KIND_WSCALE) begin
                upd.scale = beat_byte;
              end else begin
                upd.stamp = {st.stamp[55:0], beat_byte};
              end
            end
            if ({1'b0, p1} >= st.opt_end) begin
              upd.phase = tcphp_pkg::PH_KIND;
            end
          end
          tcphp_pkg::PH_STOP: begin
            upd.phase = tcphp_pkg::PH_STOP;
          end
          default: begin
            upd.phase = tcphp_pkg::PH_STOP;
          end
        endcase
      end

      reached = p1 >= 7'(tcphp_pkg::FIXED_LEN);
      priority if (reached && upd.offset < 6'(tcphp_pkg::FIXED_LEN)) begin
        emit   = 1'b1;
        status = tcphp_pkg::ST_SHORT;
      end else if (reached && p1 >= {1'b0, limit}) begin
        emit   = 1'b1;
        status = tcphp_pkg::ST_OK;
      end else if (beat_last) begin
        emit   = 1'b1;
        status = reached ? tcphp_pkg::ST_TRUNC : tcphp_pkg::ST_SHORT;
      end else begin
        emit   = 1'b0;
      end
    end else begin
      reached = 1'b0;
    end

    pres = (status == tcphp_pkg::ST_OK) ? upd.present : 3'b000;

    result.port_pair       = upd.ports;
    result.sequence_number = upd.seq;
    result.ack_number      = upd.ack;
    result.flag_bits       = {pres, upd.flags};
    result.window_size     = upd.words[47:32];
    result.checksum_field  = upd.words[31:16];
    result.urgent_pointer  = upd.words[15:0];
    result.mss_value       = pres[0] ? upd.mss : 16'd0;
    result.scale_value     = pres[1] ? upd.scale : 8'd0;
    result.timestamp_pair  = pres[2] ? upd.stamp : 64'd0;
    result.header_length   = upd.offset;
    result.parse_status    = status;

    clear   = beat_last && (st.done || emit);
    st_next = upd;
    if (clear) begin
      st_next = '0;
    end else if (emit) begin
      st_next.done = 1'b1;
    end else if (!st.done) begin
      st_next.pos = p1[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

`ifndef SYNTHESIS
  a_no_emit_when_done: assert property (@(posedge clk) disable iff (rst)
    st.done |-> !emit)
    else $error("result raised while header already done");

  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    (take && emit && !beat_last) |=> st.done)
    else $error("header not marked done after result");

  a_bad_status_no_opts: assert property (@(posedge clk) disable iff (rst)
    (emit && result.parse_status != tcphp_pkg::ST_OK) |-> (result.flag_bits[9:7] == 3'b000))
    else $error("option flags set on failed parse");

  a_phase_in_options: assert property (@(posedge clk) disable iff (rst)
    (st.phase != tcphp_pkg::PH_KIND) |-> (st.pos > 6'(tcphp_pkg::FIXED_LEN)))
    else $error("option walk active inside fixed header");
`endif

endmodule

`default_nettype wire

[design/tcphp_out_stage.sv]
// ----------------------------------------------------------------------------
// TCP header parser output stage
// Result register; holds the result beat while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tcphp_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire tcphp_pkg::result_t  result,
  input  wire logic                res_stall,
  output logic                     res_valid,
  output logic                     free,
  output tcphp_pkg::result_t       res_data
);

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= result;
    end
  end

endmodule

`default_nettype wire

[design/tcp_header_parser_core.sv]
// The beat that completes the header is held in the input register, and its result
//   in the result register. Header parsing is a single pass per byte.
// Throughput: one segment byte per cycle while seg_stall is low.
// A byte that produces a result waits only while res_valid and res_stall are high.
// Reset: synchronous rst clears the parse state and both valid registers.
// ----------------------------------------------------------------------------
// TCP header parser top level
// Byte-serial TCP fixed header and option parser with one result per segment.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_header_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        seg_valid,
  output logic             seg_stall,
  input  wire logic [7:0]  segment_byte,
  input  wire logic        last_byte,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [31:0]      port_pair,
  output logic [31:0]      sequence_number,
  output logic [31:0]      ack_number,
  output logic [9:0]       flag_bits,
  output logic [15:0]      window_size,
  output logic [15:0]      checksum_field,
  output logic [15:0]      urgent_pointer,
  output logic [15:0]      mss_value,
  output logic [7:0]       scale_value,
  output logic [63:0]      timestamp_pair,
  output logic [5:0]       header_length,
  output logic [1:0]       parse_status
);

  logic               beat_valid;
  logic [7:0]         beat_byte;
  logic               beat_last;
  logic               advance;
  logic               emit;
  logic               free;
  tcphp_pkg::result_t result;
  tcphp_pkg::result_t res_data;

  assign advance = beat_valid && (!emit || free);

  tcphp_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .seg_valid    (seg_valid),
    .seg_stall    (seg_stall),
    .segment_byte (segment_byte),
    .last_byte    (last_byte),
    .advance      (advance),
    .beat_valid   (beat_valid),
    .beat_byte    (beat_byte),
    .beat_last    (beat_last)
  );

  tcphp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (advance),
    .beat_byte (beat_byte),
    .beat_last (beat_last),
    .emit      (emit),
    .result    (result)
  );

  tcphp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .result    (result),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .free      (free),
    .res_data  (res_data)
  );

  assign port_pair       = res_data.port_pair;
  assign sequence_number = res_data.sequence_number;
  assign ack_number      = res_data.ack_number;
  assign flag_bits       = res_data.flag_bits;
  assign window_size     = res_data.window_size;
  assign checksum_field  = res_data.checksum_field;
  assign urgent_pointer  = res_data.urgent_pointer;
  assign mss_value       = res_data.mss_value;
  assign scale_value     = res_data.scale_value;
  assign timestamp_pair  = res_data.timestamp_pair;
  assign header_length   = res_data.header_length;
  assign parse_status    = res_data.parse_status;

endmodule

`default_nettype wire

[verif/tcp_header_parser_core_test.sv]
// ----------------------------------------------------------------------------
// TCP header parser core testbench
// Sends TCP segments one byte per beat and builds the expected header record
// for each segment from a byte-level model of the parser. Every record that
// the core returns is checked field by field against the oldest expected one.
// Stimulus: directed headers and option lists, short and truncated segments,
// a long result hold-off, then random segments under several idling mixes.
// ----------------------------------------------------------------------------
module tcp_header_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcphp_pkg::*;

  localparam int SEQ_AT    = 4;
  localparam int ACK_AT    = 8;
  localparam int OFFSET_AT = 12;
  localparam int FLAGS_AT  = 13;

  localparam int PRES_MSS    = 0;
  localparam int PRES_WSCALE = 1;
  localparam int PRES_TSTAMP = 2;

  localparam logic [7:0] KIND_OTHER = 8'd30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seg_valid = 1'b0;
  logic        seg_stall;
  logic [7:0]  segment_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [31:0] port_pair;
  logic [31:0] sequence_number;
  logic [31:0] ack_number;
  logic [9:0]  flag_bits;
  logic [15:0] window_size;
  logic [15:0] checksum_field;
  logic [15:0] urgent_pointer;
  logic [15:0] mss_value;
  logic [7:0]  scale_value;
  logic [63:0] timestamp_pair;
  logic [5:0]  header_length;
  logic [1:0]  parse_status;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;
  int beats_sent = 0;
  int failures = 0;

  logic [7:0] segment_q[$];
  result_t    parsed_header_q[$];

  int          hp_pos;
  bit          hp_done;
  logic [5:0]  hp_off;
  phase_t      hp_phase;
  logic [7:0]  hp_kind;
  int          hp_opt_end;
  bit          hp_accept;
  logic [31:0] hp_ports;
  logic [31:0] hp_seq;
  logic [31:0] hp_ack;
  logic [6:0]  hp_flags;
  logic [47:0] hp_words;
  logic [15:0] hp_mss;
  logic [7:0]  hp_scale;
  logic [63:0] hp_stamp;
  logic [2:0]  hp_present;

  tcp_header_parser_core dut (
    .clk(clk),
    .rst(rst),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .segment_byte(segment_byte),
    .last_byte(last_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .port_pair(port_pair),
    .sequence_number(sequence_number),
    .ack_number(ack_number),
    .flag_bits(flag_bits),
    .window_size(window_size),
    .checksum_field(checksum_field),
    .urgent_pointer(urgent_pointer),
    .mss_value(mss_value),
    .scale_value(scale_value),
    .timestamp_pair(timestamp_pair),
    .header_length(header_length),
    .parse_status(parse_status)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic clear_parse_state();
    hp_pos = 0;
    hp_done = 1'b0;
    hp_off = '0;
    hp_phase = PH_KIND;
    hp_kind = '0;
    hp_opt_end = 0;
    hp_accept = 1'b0;
    hp_ports = '0;
    hp_seq = '0;
    hp_ack = '0;
    hp_flags = '0;
    hp_words = '0;
    hp_mss = '0;
    hp_scale = '0;
    hp_stamp = '0;
    hp_present = '0;
  endtask

  function automatic int option_walk_limit();
    return (int'(hp_off) < HDR_LIMIT) ? int'(hp_off) : HDR_LIMIT;
  endfunction

  task automatic parse_header_byte(input logic [7:0] b, input logic l);
    int      p;
    int      eff;
    int      e;
    bit      exact;
    bit      fire;
    status_t st;
    logic [2:0] pres;
    result_t r;
    if (hp_done) begin
      if (l) clear_parse_state();
    end else begin
      p = hp_pos;
      if (p < FIXED_LEN) begin
        if (p < SEQ_AT) hp_ports = {hp_ports[23:0], b};
        else if (p < ACK_AT) hp_seq = {hp_seq[23:0], b};
        else if (p < OFFSET_AT) hp_ack = {hp_ack[23:0], b};
        else if (p == OFFSET_AT) hp_off = {b[7:4], 2'b00};
        else if (p == FLAGS_AT) hp_flags = b[6:0];
        else hp_words = {hp_words[39:0], b};
      end else begin
        case (hp_phase)
          PH_KIND: begin
            if (b == KIND_EOL) begin
              hp_phase = PH_STOP;
            end else if (b != KIND_NOP) begin
              hp_kind = b;
              hp_phase = PH_LEN;
            end
          end
          PH_LEN: begin
            eff = (b < 8'd2) ? 2 : int'(b);
            e = p - 1 + eff;
            exact = (hp_kind == KIND_MSS && b == LEN_MSS) ||
                    (hp_kind == KIND_WSCALE && b == LEN_WSCALE) ||
                    (hp_kind == KIND_TSTAMP && b == LEN_TSTAMP);
            if (e > 255) e = 255;
            hp_opt_end = e;
            hp_accept = exact && (e <= option_walk_limit());
            if (hp_accept) begin
              if (hp_kind == KIND_MSS) hp_present[PRES_MSS] = 1'b1;
              else if (hp_kind == KIND_WSCALE) hp_present[PRES_WSCALE] = 1'b1;
              else hp_present[PRES_TSTAMP] = 1'b1;
            end
            hp_phase = (p + 1 >= e) ? PH_KIND : PH_DATA;
          end
          PH_DATA: begin
            if (hp_accept) begin
              if (hp_kind == KIND_MSS) hp_mss = {hp_mss[7:0], b};
              else if (hp_kind == KIND_WSCALE) hp_scale = b;
              else hp_stamp = {hp_stamp[55:0], b};
            end
            if (p + 1 >= hp_opt_end) hp_phase = PH_KIND;
          end
          default: begin
          end
        endcase
      end

      fire = 1'b1;
      st = ST_OK;
      if (p + 1 >= FIXED_LEN && int'(hp_off) < FIXED_LEN) st = ST_SHORT;
      else if (p + 1 >= FIXED_LEN && p + 1 >= option_walk_limit()) st = ST_OK;
      else if (l) st = (p + 1 < FIXED_LEN) ? ST_SHORT : ST_TRUNC;
      else fire = 1'b0;

      if (fire) begin
        pres = (st == ST_OK) ? hp_present : 3'b000;
        r.port_pair = hp_ports;
        r.sequence_number = hp_seq;
        r.ack_number = hp_ack;
        r.flag_bits = {pres, hp_flags};
        r.window_size = hp_words[47:32];
        r.checksum_field = hp_words[31:16];
        r.urgent_pointer = hp_words[15:0];
        r.mss_value = pres[PRES_MSS] ? hp_mss : '0;
        r.scale_value = pres[PRES_WSCALE] ? hp_scale : '0;
        r.timestamp_pair = pres[PRES_TSTAMP] ? hp_stamp : '0;
        r.header_length = hp_off;
        r.parse_status = st;
        parsed_header_q.push_back(r);
        hp_done = 1'b1;
        if (l) clear_parse_state();
      end else begin
        hp_pos = (p + 1) % 64;
      end
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      seg_valid = 1'b0;
      @(negedge clk);
    end
    seg_valid = 1'b1;
    segment_byte = b;
    last_byte = l;
    do @(posedge clk); while (seg_stall);
    parse_header_byte(b, l);
    beats_sent++;
  endtask

  task automatic send_segment();
    foreach (segment_q[i]) send_beat(segment_q[i], i == segment_q.size() - 1);
  endtask

  task automatic add_header(input logic [3:0] nib);
    for (int i = 0; i < FIXED_LEN; i++)
      segment_q.push_back((i == OFFSET_AT) ? {nib, 4'($urandom)} : 8'($urandom));
  endtask

  task automatic add_option(input logic [7:0] kind, input logic [7:0] len);
    int n;
    segment_q.push_back(kind);
    if (kind != KIND_EOL && kind != KIND_NOP) begin
      segment_q.push_back(len);
      n = (len < 8'd2) ? 0 : int'(len) - 2;
      if (n > 40) n = 40;
      repeat (n) segment_q.push_back(8'($urandom));
    end
  endtask

  task automatic trim_segment(input int keep);
    while (segment_q.size() > keep) void'(segment_q.pop_back());
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) note_failure($sformatf("%s expected %h got %h", name, want, got));
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall = 1'b1;
      hold_left--;
    end else begin
      res_stall = ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (parsed_header_q.size() == 0) begin
        note_failure($sformatf("unexpected result, port_pair %h", port_pair));
      end else begin
        want = parsed_header_q.pop_front();
        compare_field("port_pair", want.port_pair, port_pair);
        compare_field("sequence_number", want.sequence_number, sequence_number);
        compare_field("ack_number", want.ack_number, ack_number);
        compare_field("flag_bits", want.flag_bits, flag_bits);
        compare_field("window_size", want.window_size, window_size);
        compare_field("checksum_field", want.checksum_field, checksum_field);
        compare_field("urgent_pointer", want.urgent_pointer, urgent_pointer);
        compare_field("mss_value", want.mss_value, mss_value);
        compare_field("scale_value", want.scale_value, scale_value);
        compare_field("timestamp_pair", want.timestamp_pair, timestamp_pair);
        compare_field("header_length", want.header_length, header_length);
        compare_field("parse_status", want.parse_status, parse_status);
      end
    end
  end

  task automatic test_header_extremes();
    src_idle_pct = 18;
    sink_stall_pct = 18;
    segment_q.delete();
    repeat (FIXED_LEN) segment_q.push_back(8'h00);
    send_segment();
    segment_q.delete();
    repeat (HDR_LIMIT) segment_q.push_back(8'hFF);
    send_segment();
    segment_q.delete();
    add_header(4'd5);
    repeat (3) segment_q.push_back(8'($urandom));
    send_segment();
  endtask

  task automatic test_option_walk();
    segment_q.delete();
    add_header(4'd15);
    add_option(KIND_MSS, LEN_MSS);
    add_option(KIND_WSCALE, LEN_WSCALE);
    add_option(KIND_NOP, 8'd0);
    add_option(KIND_TSTAMP, LEN_TSTAMP);
    add_option(KIND_MSS, LEN_MSS);
    add_option(KIND_EOL, 8'd0);
    while (segment_q.size() < HDR_LIMIT) segment_q.push_back(8'($urandom));
    send_segment();
    // length below two, wrong lengths, last option cut by the header end
    segment_q.delete();
    add_header(4'd10);
    add_option(KIND_OTHER, 8'd0);
    add_option(KIND_OTHER, 8'd1);
    add_option(KIND_MSS, LEN_MSS + 8'd1);
    add_option(KIND_WSCALE, LEN_WSCALE + 8'd1);
    add_option(KIND_TSTAMP, LEN_TSTAMP - 8'd1);
    trim_segment(40);
    send_segment();
    segment_q.delete();
    add_header(4'd6);
    add_option(KIND_TSTAMP, LEN_TSTAMP);
    send_segment();
    segment_q.delete();
    add_header(4'd6);
    repeat (3) add_option(KIND_NOP, 8'd0);
    add_option(KIND_MSS, LEN_MSS);
    send_segment();
    segment_q.delete();
    add_header(4'd6);
    repeat (2) add_option(KIND_NOP, 8'd0);
    add_option(KIND_WSCALE, LEN_WSCALE);
    send_segment();
  endtask

  task automatic test_short_and_truncated();
    segment_q.delete();
    segment_q.push_back(8'($urandom));
    send_segment();
    segment_q.delete();
    add_header(4'd9);
    trim_segment(OFFSET_AT + 1);
    send_segment();
    segment_q.delete();
    add_header(4'd5);
    trim_segment(FIXED_LEN - 1);
    send_segment();
    segment_q.delete();
    add_header(4'd3);
    repeat (2) segment_q.push_back(8'($urandom));
    send_segment();
    segment_q.delete();
    add_header(4'd10);
    send_segment();
    segment_q.delete();
    add_header(4'd12);
    add_option(KIND_MSS, LEN_MSS);
    add_option(KIND_WSCALE, LEN_WSCALE);
    repeat (5) segment_q.push_back(8'($urandom));
    send_segment();
  endtask

  task automatic test_result_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = 400;
    repeat (12) begin
      segment_q.delete();
      if ($urandom_range(1)) segment_q.push_back(8'($urandom));
      else add_header(4'd5);
      send_segment();
    end
  endtask

  task automatic build_random_segment();
    int nib;
    int pick;
    logic [7:0] kind;
    segment_q.delete();
    if ($urandom_range(99) < 4) begin
      repeat ($urandom_range(64, 1)) segment_q.push_back(8'($urandom));
    end else begin
      nib = ($urandom_range(9) < 8) ? $urandom_range(15, 5) : $urandom_range(4, 0);
      add_header(4'(nib));
      while (segment_q.size() < nib * 4) begin
        pick = $urandom_range(99);
        case ($urandom_range(2))
          0: kind = KIND_MSS;
          1: kind = KIND_WSCALE;
          default: kind = KIND_TSTAMP;
        endcase
        if (pick < 15) add_option(KIND_NOP, 8'd0);
        else if (pick < 19) add_option(KIND_EOL, 8'd0);
        else if (pick < 39) add_option(KIND_MSS, LEN_MSS);
        else if (pick < 54) add_option(KIND_WSCALE, LEN_WSCALE);
        else if (pick < 72) add_option(KIND_TSTAMP, LEN_TSTAMP);
        else if (pick < 86) add_option(kind, 8'($urandom_range(12)));
        else if (pick < 97) add_option(8'($urandom), 8'($urandom_range(16)));
        else add_option(8'($urandom), 8'($urandom));
      end
      repeat ($urandom_range(4)) segment_q.push_back(8'($urandom));
      if ($urandom_range(99) < 12) trim_segment($urandom_range(segment_q.size(), 1));
    end
  endtask

  task automatic test_random_segments(input int budget, input int idle_pct,
                                      input int stall_pct);
    int stop_at;
    stop_at = beats_sent + budget;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    while (beats_sent < stop_at) begin
      build_random_segment();
      send_segment();
    end
  endtask

  initial begin
    clear_parse_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_header_extremes();
    test_option_walk();
    test_short_and_truncated();
    test_result_backpressure();
    test_random_segments(310, 0, 0);
    test_random_segments(310, 69, 0);
    test_random_segments(310, 0, 69);
    test_random_segments(320, 18, 18);
    @(negedge clk);
    seg_valid = 1'b0;
    while (parsed_header_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[tcp_header_parser_core.f]
design/tcphp_pkg.sv
design/tcphp_in_stage.sv
design/tcphp_parse.sv
design/tcphp_out_stage.sv
design/tcp_header_parser_core.sv
verif/tcp_header_parser_core_test.sv
